// ===== src/crcag_pkg.sv =====
// ----------------------------------------------------------------------------
// crcag_pkg
// shared constants and types for the clipped rectangle copy address generator
// ----------------------------------------------------------------------------
package crcag_pkg;

  localparam int ADDR_BITS  = 30;
  localparam int COORD_BITS = 12;
  localparam int POS_BITS   = 16;
  localparam int SCAN_BITS  = 16;
  localparam int CNT_BITS   = COORD_BITS + 1;
  localparam int OFF_BITS   = COORD_BITS + 2;
  localparam int EXT_BITS   = POS_BITS + 2;
  localparam int PROD_BITS  = OFF_BITS + SCAN_BITS;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = SCAN_BITS;

  localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_LEFT   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_TOP    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_RIGHT  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_BOTTOM = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCANLINE    = 3'd4;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  localparam logic [SCAN_BITS-1:0] SCANLINE_RESET = 16'd4096;
  localparam logic signed [EXT_BITS-1:0] EXT_ONE  = 1;

  typedef struct packed {
    logic                  empty;
    logic [COORD_BITS-1:0] x1;
    logic [COORD_BITS-1:0] y1;
    logic [OFF_BITS-1:0]   xs;
    logic [OFF_BITS-1:0]   ys;
    logic [CNT_BITS-1:0]   w;
    logic [CNT_BITS-1:0]   h;
  } clip_res_t;

endpackage

// ===== src/crcag_in_if.sv =====
// ----------------------------------------------------------------------------
// crcag_in_if
// command channel: load and advance transactions
// ----------------------------------------------------------------------------
interface crcag_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic [crcag_pkg::ADDR_BITS-1:0]     dest_base;
  logic signed [crcag_pkg::POS_BITS-1:0] dest_x;
  logic signed [crcag_pkg::POS_BITS-1:0] dest_y;
  logic [crcag_pkg::CNT_BITS-1:0]      rect_width;
  logic [crcag_pkg::CNT_BITS-1:0]      rect_height;
  logic [crcag_pkg::ADDR_BITS-1:0]     src_base;
  logic [crcag_pkg::COORD_BITS-1:0]    src_x;
  logic [crcag_pkg::COORD_BITS-1:0]    src_y;

  modport source (
    output valid, kind, dest_base, dest_x, dest_y, rect_width, rect_height,
           src_base, src_x, src_y,
    input  ready
  );
  modport sink (
    input  valid, kind, dest_base, dest_x, dest_y, rect_width, rect_height,
           src_base, src_x, src_y,
    output ready
  );
endinterface

interface crcag_out_if;
  logic                            valid;
  logic                            ready;
  logic                            has_move;
  logic [crcag_pkg::ADDR_BITS-1:0] src_addr;
  logic [crcag_pkg::ADDR_BITS-1:0] dest_addr;
  logic                            last;
  logic                            busy_res;

  modport source (
    output valid, has_move, src_addr, dest_addr, last, busy_res,
    input  ready
  );
  modport sink (
    input  valid, has_move, src_addr, dest_addr, last, busy_res,
    output ready
  );
endinterface

// ===== src/crcag_clip.sv =====
// ----------------------------------------------------------------------------
// crcag_clip
// clips the destination rectangle and shifts the source corner to match
// ----------------------------------------------------------------------------
module crcag_clip (
  input  logic signed [crcag_pkg::POS_BITS-1:0] dest_x,
  input  logic signed [crcag_pkg::POS_BITS-1:0] dest_y,
  input  logic [crcag_pkg::CNT_BITS-1:0]        rect_width,
  input  logic [crcag_pkg::CNT_BITS-1:0]        rect_height,
  input  logic [crcag_pkg::COORD_BITS-1:0]      src_x,
  input  logic [crcag_pkg::COORD_BITS-1:0]      src_y,
  input  logic [crcag_pkg::COORD_BITS-1:0]      clip_left,
  input  logic [crcag_pkg::COORD_BITS-1:0]      clip_top,
  input  logic [crcag_pkg::COORD_BITS-1:0]      clip_right,
  input  logic [crcag_pkg::COORD_BITS-1:0]      clip_bottom,
  output crcag_pkg::clip_res_t                  res
);

  logic signed [crcag_pkg::EXT_BITS-1:0] x1, y1, x2, y2, ww, hh;
  logic signed [crcag_pkg::EXT_BITS-1:0] cl, ct, cr, cb;
  logic signed [crcag_pkg::EXT_BITS-1:0] x1c, y1c, x2c, y2c, dx, dy, wd, hd;
  logic                                  clip_l, clip_t;

  always_comb begin
    x1 = {{(crcag_pkg::EXT_BITS-crcag_pkg::POS_BITS){dest_x[crcag_pkg::POS_BITS-1]}}, dest_x};
    y1 = {{(crcag_pkg::EXT_BITS-crcag_pkg::POS_BITS){dest_y[crcag_pkg::POS_BITS-1]}}, dest_y};
    ww = {{(crcag_pkg::EXT_BITS-crcag_pkg::CNT_BITS){1'b0}}, rect_width};
    hh = {{(crcag_pkg::EXT_BITS-crcag_pkg::CNT_BITS){1'b0}}, rect_height};
    cl = {{(crcag_pkg::EXT_BITS-crcag_pkg::COORD_BITS){1'b0}}, clip_left};
    ct = {{(crcag_pkg::EXT_BITS-crcag_pkg::COORD_BITS){1'b0}}, clip_top};
    cr = {{(crcag_pkg::EXT_BITS-crcag_pkg::COORD_BITS){1'b0}}, clip_right};
    cb = {{(crcag_pkg::EXT_BITS-crcag_pkg::COORD_BITS){1'b0}}, clip_bottom};
    x2 = x1 + ww - crcag_pkg::EXT_ONE;
    y2 = y1 + hh - crcag_pkg::EXT_ONE;

    clip_l = x1 < cl;
    clip_t = y1 < ct;
    dx  = cl - x1;
    dy  = ct - y1;
    x1c = clip_l ? cl : x1;
    y1c = clip_t ? ct : y1;
    x2c = (x2 > cr) ? cr : x2;
    y2c = (y2 > cb) ? cb : y2;
    wd  = x2c - x1c;
    hd  = y2c - y1c;

    // offsets stay below four times the clip span whenever the result is used
    res.empty = (wd < 0) || (hd < 0);
    res.x1    = x1c[crcag_pkg::COORD_BITS-1:0];
    res.y1    = y1c[crcag_pkg::COORD_BITS-1:0];
    res.xs    = crcag_pkg::OFF_BITS'(src_x)
              + (clip_l ? dx[crcag_pkg::OFF_BITS-1:0] : '0);
    res.ys    = crcag_pkg::OFF_BITS'(src_y)
              + (clip_t ? dy[crcag_pkg::OFF_BITS-1:0] : '0);
    res.w     = wd[crcag_pkg::CNT_BITS-1:0] + crcag_pkg::CNT_BITS'(1);
    res.h     = hd[crcag_pkg::CNT_BITS-1:0] + crcag_pkg::CNT_BITS'(1);
  end

endmodule

// ===== src/clipped_rect_copy_address_gen_top.sv =====
// ----------------------------------------------------------------------------
// clipped_rect_copy_address_gen_top
// clipped rectangle copy address generator: clip, row start product, cursor walk
// ----------------------------------------------------------------------------
// an accepted transaction passes stage a, stage b and the output register before its result is on out_ch
// throughput: one transaction per cycle while out_ch takes results, every transaction gives one result
// stages: clip, scanline multiply, cursor/state update into the output register
// all stages advance together whenever the output register is empty or taken
// reset (rst_n, synchronous): pipeline empty, copy idle, clip to full frame,
// scanline 4096 bytes
module clipped_rect_copy_address_gen_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  crcag_in_if.sink                               in_ch,
  crcag_out_if.source                            out_ch,
  input  logic                                   cfg_we,
  input  logic [crcag_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [crcag_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

  // configuration
  logic [crcag_pkg::COORD_BITS-1:0] clip_left_r, clip_top_r, clip_right_r, clip_bottom_r;
  logic [crcag_pkg::SCAN_BITS-1:0]  scanline_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_left_r   <= '0;
      clip_top_r    <= '0;
      clip_right_r  <= '1;
      clip_bottom_r <= '1;
      scanline_r    <= crcag_pkg::SCANLINE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        crcag_pkg::CFG_CLIP_LEFT:   clip_left_r   <= cfg_wdata[crcag_pkg::COORD_BITS-1:0];
        crcag_pkg::CFG_CLIP_TOP:    clip_top_r    <= cfg_wdata[crcag_pkg::COORD_BITS-1:0];
        crcag_pkg::CFG_CLIP_RIGHT:  clip_right_r  <= cfg_wdata[crcag_pkg::COORD_BITS-1:0];
        crcag_pkg::CFG_CLIP_BOTTOM: clip_bottom_r <= cfg_wdata[crcag_pkg::COORD_BITS-1:0];
        crcag_pkg::CFG_SCANLINE:    scanline_r    <= cfg_wdata[crcag_pkg::SCAN_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_valid_r;
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // stage a: clip
  crcag_pkg::clip_res_t clip_res, a_clip_r;
  logic                             a_valid_r, a_kind_r;
  logic [crcag_pkg::ADDR_BITS-1:0]  a_src_base_r, a_dest_base_r;

  crcag_clip u_clip (
    .dest_x      (in_ch.dest_x),
    .dest_y      (in_ch.dest_y),
    .rect_width  (in_ch.rect_width),
    .rect_height (in_ch.rect_height),
    .src_x       (in_ch.src_x),
    .src_y       (in_ch.src_y),
    .clip_left   (clip_left_r),
    .clip_top    (clip_top_r),
    .clip_right  (clip_right_r),
    .clip_bottom (clip_bottom_r),
    .res         (clip_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_kind_r      <= in_ch.kind;
      a_clip_r      <= clip_res;
      a_src_base_r  <= in_ch.src_base;
      a_dest_base_r <= in_ch.dest_base;
    end
  end

  // stage b: row offset products and base plus column
  logic [crcag_pkg::PROD_BITS-1:0] src_prod, dest_prod;
  logic                            b_valid_r, b_kind_r, b_empty_r;
  logic [crcag_pkg::CNT_BITS-1:0]  b_w_r, b_h_r;
  logic [crcag_pkg::ADDR_BITS-1:0] b_src_off_r, b_dest_off_r, b_src_bx_r, b_dest_bx_r;

  assign src_prod  = {{crcag_pkg::SCAN_BITS{1'b0}}, a_clip_r.ys}
                   * {{crcag_pkg::OFF_BITS{1'b0}}, scanline_r};
  assign dest_prod = {{(crcag_pkg::PROD_BITS-crcag_pkg::COORD_BITS){1'b0}}, a_clip_r.y1}
                   * {{crcag_pkg::OFF_BITS{1'b0}}, scanline_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_kind_r     <= a_kind_r;
      b_empty_r    <= a_clip_r.empty;
      b_w_r        <= a_clip_r.w;
      b_h_r        <= a_clip_r.h;
      b_src_off_r  <= crcag_pkg::ADDR_BITS'(src_prod >> 2);
      b_dest_off_r <= crcag_pkg::ADDR_BITS'(dest_prod >> 2);
      b_src_bx_r   <= a_src_base_r + crcag_pkg::ADDR_BITS'(a_clip_r.xs);
      b_dest_bx_r  <= a_dest_base_r + crcag_pkg::ADDR_BITS'(a_clip_r.x1);
    end
  end

  // stage c: copy state and result register
  logic [crcag_pkg::ADDR_BITS-1:0] src_row_r, dest_row_r, src_cur_r, dest_cur_r;
  logic [crcag_pkg::ADDR_BITS-1:0] src_row_nxt, dest_row_nxt, src_cur_nxt, dest_cur_nxt;
  logic [crcag_pkg::CNT_BITS-1:0]  row_len_r, cols_r, rows_r;
  logic [crcag_pkg::CNT_BITS-1:0]  row_len_nxt, cols_nxt, rows_nxt, cols_dec, rows_dec;
  logic                            active_r, active_nxt;
  logic [crcag_pkg::ADDR_BITS-1:0] step, src_new_row, dest_new_row;
  logic                            has_move_r, last_r, busy_r;
  logic                            has_move_nxt, last_nxt, busy_nxt;
  logic [crcag_pkg::ADDR_BITS-1:0] src_addr_r, dest_addr_r, src_addr_nxt, dest_addr_nxt;

  assign step         = crcag_pkg::ADDR_BITS'(scanline_r >> 2);
  assign src_new_row  = src_row_r + step;
  assign dest_new_row = dest_row_r + step;
  assign cols_dec     = cols_r - crcag_pkg::CNT_BITS'(1);
  assign rows_dec     = rows_r - crcag_pkg::CNT_BITS'(1);

  always_comb begin
    src_row_nxt   = src_row_r;
    dest_row_nxt  = dest_row_r;
    src_cur_nxt   = src_cur_r;
    dest_cur_nxt  = dest_cur_r;
    row_len_nxt   = row_len_r;
    cols_nxt      = cols_r;
    rows_nxt      = rows_r;
    active_nxt    = active_r;
    has_move_nxt  = 1'b0;
    last_nxt      = 1'b0;
    busy_nxt      = 1'b0;
    src_addr_nxt  = '0;
    dest_addr_nxt = '0;
    if (b_kind_r == crcag_pkg::KIND_LOAD) begin
      if (b_empty_r) begin
        active_nxt  = 1'b0;
        row_len_nxt = '0;
        cols_nxt    = '0;
        rows_nxt    = '0;
      end else begin
        src_row_nxt  = b_src_bx_r + b_src_off_r;
        dest_row_nxt = b_dest_bx_r + b_dest_off_r;
        src_cur_nxt  = src_row_nxt;
        dest_cur_nxt = dest_row_nxt;
        row_len_nxt  = b_w_r;
        cols_nxt     = b_w_r;
        rows_nxt     = b_h_r;
        active_nxt   = 1'b1;
        busy_nxt     = 1'b1;
      end
    end else if (active_r) begin
      has_move_nxt  = 1'b1;
      src_addr_nxt  = src_cur_r;
      dest_addr_nxt = dest_cur_r;
      cols_nxt      = cols_dec;
      if (cols_dec != '0) begin
        src_cur_nxt  = src_cur_r + crcag_pkg::ADDR_BITS'(1);
        dest_cur_nxt = dest_cur_r + crcag_pkg::ADDR_BITS'(1);
        busy_nxt     = 1'b1;
      end else begin
        rows_nxt = rows_dec;
        if (rows_dec == '0) begin
          active_nxt = 1'b0;
          last_nxt   = 1'b1;
        end else begin
          src_row_nxt  = src_new_row;
          dest_row_nxt = dest_new_row;
          src_cur_nxt  = src_new_row;
          dest_cur_nxt = dest_new_row;
          cols_nxt     = row_len_r;
          busy_nxt     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      row_len_r   <= '0;
      cols_r      <= '0;
      rows_r      <= '0;
      src_row_r   <= '0;
      dest_row_r  <= '0;
      src_cur_r   <= '0;
      dest_cur_r  <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= b_valid_r;
      if (b_valid_r) begin
        active_r   <= active_nxt;
        row_len_r  <= row_len_nxt;
        cols_r     <= cols_nxt;
        rows_r     <= rows_nxt;
        src_row_r  <= src_row_nxt;
        dest_row_r <= dest_row_nxt;
        src_cur_r  <= src_cur_nxt;
        dest_cur_r <= dest_cur_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && b_valid_r) begin
      has_move_r  <= has_move_nxt;
      last_r      <= last_nxt;
      busy_r      <= busy_nxt;
      src_addr_r  <= src_addr_nxt;
      dest_addr_r <= dest_addr_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.has_move  = has_move_r;
  assign out_ch.src_addr  = src_addr_r;
  assign out_ch.dest_addr = dest_addr_r;
  assign out_ch.last      = last_r;
  assign out_ch.busy_res  = busy_r;

endmodule
